// ===== rtl/i2cees_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cees_pkg: shared types and codes of the I2C EEPROM transfer sequencer
// Bus action codes, result entry and result group types, helper functions.
// ----------------------------------------------------------------------------
package i2cees_pkg;

    localparam int ADDRESS_WIDTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT   = 4;
    localparam int GROUP_SIZE            = 4;

    // bus actions shown on the result channel
    localparam logic [3:0] A_START = 4'd0;
    localparam logic [3:0] A_SEND  = 4'd1;
    localparam logic [3:0] A_READ  = 4'd2;
    localparam logic [3:0] A_ACK   = 4'd3;
    localparam logic [3:0] A_NACK  = 4'd4;
    localparam logic [3:0] A_STOP  = 4'd5;
    localparam logic [3:0] A_DONE  = 4'd6;
    localparam logic [3:0] A_RDATA = 4'd7;
    localparam logic [3:0] A_WANT  = 4'd8;

    typedef struct packed {
        logic [3:0] action;
        logic [7:0] byte_val;
        logic       success;
    } res_entry_t;

    // results caused by one request, sent in order ent[0] .. ent[count-1]
    typedef struct packed {
        logic [2:0]                       count;
        res_entry_t [GROUP_SIZE-1:0]      ent;
    } res_group_t;

    function automatic res_entry_t mk_entry(input logic [3:0] action,
                                            input logic [7:0] byte_val,
                                            input logic       success);
        res_entry_t e;
        e.action   = action;
        e.byte_val = byte_val;
        e.success  = success;
        return e;
    endfunction

    // device byte: in one-byte address mode the high address bits ride in bits 7..1
    function automatic logic [7:0] dev_byte(input logic [7:0]  dsel,
                                            input logic [1:0]  abc,
                                            input logic [15:0] addr,
                                            input logic        rw);
        logic [7:0] b;
        b = {dsel[7:1], rw};
        if (abc != 2'd2)
        begin
            b = b | {addr[14:8], 1'b0};
        end
        return b;
    endfunction

endpackage

// ===== rtl/i2cees_front.sv =====
// ----------------------------------------------------------------------------
// i2cees_front: request decoder and transfer state
// Accepts commands and bus events, updates the transfer state and pushes the
// group of bus actions each request causes into the result queue.
// ----------------------------------------------------------------------------
module i2cees_front #(
    parameter int ADDRESS_WIDTH = i2cees_pkg::ADDRESS_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             op,
    input  logic [15:0]            start_address,
    input  logic [15:0]            byte_count,
    input  logic [7:0]             data_byte,
    input  logic                   no_ack,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [16:0]            cfg_data,
    input  logic                   queue_full,
    output logic                   push,
    output i2cees_pkg::res_group_t push_group
);

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_WDATA = 3'd2;
    localparam logic [2:0] OP_ACK   = 3'd3;
    localparam logic [2:0] OP_RXB   = 3'd4;

    localparam logic [2:0] CFG_DSEL  = 3'd0;
    localparam logic [2:0] CFG_ABC   = 3'd1;
    localparam logic [2:0] CFG_PAGE  = 3'd2;
    localparam logic [2:0] CFG_MSIZE = 3'd3;
    localparam logic [2:0] CFG_POLL  = 3'd4;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_DEV  = 3'd1;
    localparam logic [2:0] PH_AHI  = 3'd2;
    localparam logic [2:0] PH_ALO  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_WACK = 3'd5;
    localparam logic [2:0] PH_RDEV = 3'd6;
    localparam logic [2:0] PH_RX   = 3'd7;

    logic [7:0]  dsel_reg;
    logic [1:0]  abc_reg;
    logic [3:0]  page_reg;
    logic [16:0] msize_reg;
    logic [9:0]  plimit_reg;

    logic [2:0]               phase_reg, phase_next;
    logic                     is_read_reg, is_read_next;
    logic [ADDRESS_WIDTH-1:0] cur_reg, cur_next;
    logic [16:0]              left_reg, left_next;
    logic [9:0]               poll_reg, poll_next;

    i2cees_pkg::res_group_t grp;
    logic                     accept;
    logic [ADDRESS_WIDTH-1:0] new_addr;
    logic [ADDRESS_WIDTH-1:0] cur_inc;
    logic [15:0]              cur16;
    logic [15:0]              cur_inc16;
    logic [15:0]              pmask;
    logic [16:0]              addr_sum;
    logic [16:0]              left_dec;
    logic [9:0]               poll_inc;

    assign in_ready   = !queue_full;
    assign cfg_ready  = 1'b1;
    assign accept     = in_valid && in_ready;
    assign push       = accept && (grp.count != 3'd0);
    assign push_group = grp;

    assign new_addr  = start_address[ADDRESS_WIDTH-1:0];
    assign cur_inc   = cur_reg + 1'b1;
    assign cur16     = 16'(cur_reg);
    assign cur_inc16 = 16'(cur_inc);
    assign pmask     = (16'd1 << page_reg) - 16'd1;
    assign addr_sum  = {1'b0, start_address} + {1'b0, byte_count};
    assign left_dec  = left_reg - 17'd1;
    assign poll_inc  = poll_reg + 10'd1;

    always_comb
    begin
        grp          = '0;
        phase_next   = phase_reg;
        is_read_next = is_read_reg;
        cur_next     = cur_reg;
        left_next    = left_reg;
        poll_next    = poll_reg;
        case (op)
            OP_WRITE, OP_READ:
            begin
                is_read_next = op[0];
                cur_next     = new_addr;
                left_next    = {1'b0, byte_count};
                poll_next    = '0;
                if (addr_sum > msize_reg)
                begin
                    grp.count  = 3'd2;
                    grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_STOP, 8'd0, 1'b0);
                    grp.ent[1] = i2cees_pkg::mk_entry(i2cees_pkg::A_DONE, 8'd0, 1'b0);
                    phase_next = PH_IDLE;
                end
                else if (op == OP_WRITE && byte_count == 16'd0)
                begin
                    grp.count  = 3'd2;
                    grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_STOP, 8'd0, 1'b0);
                    grp.ent[1] = i2cees_pkg::mk_entry(i2cees_pkg::A_DONE, 8'd0, 1'b1);
                    phase_next = PH_IDLE;
                end
                else
                begin
                    grp.count  = 3'd3;
                    grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_STOP, 8'd0, 1'b0);
                    grp.ent[1] = i2cees_pkg::mk_entry(i2cees_pkg::A_START, 8'd0, 1'b0);
                    grp.ent[2] = i2cees_pkg::mk_entry(i2cees_pkg::A_SEND,
                        i2cees_pkg::dev_byte(dsel_reg, abc_reg, 16'(new_addr), 1'b0), 1'b0);
                    phase_next = PH_DEV;
                end
            end
            OP_WDATA:
            begin
                if (phase_reg == PH_DATA)
                begin
                    grp.count  = 3'd1;
                    grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_SEND, data_byte, 1'b0);
                    phase_next = PH_WACK;
                end
            end
            OP_ACK:
            begin
                // a missing ack in the address, write ack or read device phases fails the transfer
                if (no_ack && phase_reg != PH_IDLE && phase_reg != PH_DATA
                    && phase_reg != PH_RX && phase_reg != PH_DEV)
                begin
                    grp.count  = 3'd2;
                    grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_STOP, 8'd0, 1'b0);
                    grp.ent[1] = i2cees_pkg::mk_entry(i2cees_pkg::A_DONE, 8'd0, 1'b0);
                    phase_next = PH_IDLE;
                end
                else
                begin
                    case (phase_reg)
                        PH_DEV:
                        begin
                            if (no_ack)
                            begin
                                poll_next = poll_inc;
                                if (poll_inc >= plimit_reg || poll_inc == 10'd0)
                                begin
                                    grp.count  = 3'd2;
                                    grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_STOP,
                                                                      8'd0, 1'b0);
                                    grp.ent[1] = i2cees_pkg::mk_entry(i2cees_pkg::A_DONE,
                                                                      8'd0, 1'b0);
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    grp.count  = 3'd2;
                                    grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_START,
                                                                      8'd0, 1'b0);
                                    grp.ent[1] = i2cees_pkg::mk_entry(i2cees_pkg::A_SEND,
                                        i2cees_pkg::dev_byte(dsel_reg, abc_reg, cur16, 1'b0),
                                        1'b0);
                                end
                            end
                            else if (abc_reg == 2'd2)
                            begin
                                grp.count  = 3'd1;
                                grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_SEND,
                                                                  cur16[15:8], 1'b0);
                                phase_next = PH_AHI;
                            end
                            else
                            begin
                                grp.count  = 3'd1;
                                grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_SEND,
                                                                  cur16[7:0], 1'b0);
                                phase_next = PH_ALO;
                            end
                        end
                        PH_AHI:
                        begin
                            grp.count  = 3'd1;
                            grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_SEND,
                                                              cur16[7:0], 1'b0);
                            phase_next = PH_ALO;
                        end
                        PH_ALO:
                        begin
                            if (is_read_reg)
                            begin
                                // repeated start, then device byte with the read bit
                                grp.count  = 3'd2;
                                grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_START,
                                                                  8'd0, 1'b0);
                                grp.ent[1] = i2cees_pkg::mk_entry(i2cees_pkg::A_SEND,
                                    i2cees_pkg::dev_byte(dsel_reg, abc_reg, cur16, 1'b1),
                                    1'b0);
                                phase_next = PH_RDEV;
                            end
                            else
                            begin
                                grp.count  = 3'd1;
                                grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_WANT,
                                                                  8'd0, 1'b0);
                                phase_next = PH_DATA;
                            end
                        end
                        PH_WACK:
                        begin
                            cur_next  = cur_inc;
                            left_next = left_dec;
                            if (left_dec == 17'd0)
                            begin
                                grp.count  = 3'd2;
                                grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_STOP,
                                                                  8'd0, 1'b0);
                                grp.ent[1] = i2cees_pkg::mk_entry(i2cees_pkg::A_DONE,
                                                                  8'd0, 1'b1);
                                phase_next = PH_IDLE;
                            end
                            else if ((cur_inc16 & pmask) == 16'd0)
                            begin
                                // page boundary: re-address the device
                                grp.count  = 3'd3;
                                grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_STOP,
                                                                  8'd0, 1'b0);
                                grp.ent[1] = i2cees_pkg::mk_entry(i2cees_pkg::A_START,
                                                                  8'd0, 1'b0);
                                grp.ent[2] = i2cees_pkg::mk_entry(i2cees_pkg::A_SEND,
                                    i2cees_pkg::dev_byte(dsel_reg, abc_reg, cur_inc16, 1'b0),
                                    1'b0);
                                poll_next  = '0;
                                phase_next = PH_DEV;
                            end
                            else
                            begin
                                grp.count  = 3'd1;
                                grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_WANT,
                                                                  8'd0, 1'b0);
                                phase_next = PH_DATA;
                            end
                        end
                        PH_RDEV:
                        begin
                            if (left_reg == 17'd0)
                            begin
                                grp.count  = 3'd2;
                                grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_STOP,
                                                                  8'd0, 1'b0);
                                grp.ent[1] = i2cees_pkg::mk_entry(i2cees_pkg::A_DONE,
                                                                  8'd0, 1'b1);
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                grp.count  = 3'd1;
                                grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_READ,
                                                                  8'd0, 1'b0);
                                phase_next = PH_RX;
                            end
                        end
                        default:
                        begin
                            grp.count = 3'd0;
                        end
                    endcase
                end
            end
            OP_RXB:
            begin
                if (phase_reg == PH_RX)
                begin
                    cur_next   = cur_inc;
                    left_next  = left_dec;
                    grp.ent[0] = i2cees_pkg::mk_entry(i2cees_pkg::A_RDATA, data_byte, 1'b0);
                    if (left_dec != 17'd0)
                    begin
                        grp.count  = 3'd3;
                        grp.ent[1] = i2cees_pkg::mk_entry(i2cees_pkg::A_ACK, 8'd0, 1'b0);
                        grp.ent[2] = i2cees_pkg::mk_entry(i2cees_pkg::A_READ, 8'd0, 1'b0);
                    end
                    else
                    begin
                        grp.count  = 3'd4;
                        grp.ent[1] = i2cees_pkg::mk_entry(i2cees_pkg::A_NACK, 8'd0, 1'b0);
                        grp.ent[2] = i2cees_pkg::mk_entry(i2cees_pkg::A_STOP, 8'd0, 1'b0);
                        grp.ent[3] = i2cees_pkg::mk_entry(i2cees_pkg::A_DONE, 8'd0, 1'b1);
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                grp.count = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            is_read_reg <= 1'b0;
            cur_reg     <= '0;
            left_reg    <= '0;
            poll_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            is_read_reg <= is_read_next;
            cur_reg     <= cur_next;
            left_reg    <= left_next;
            poll_reg    <= poll_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dsel_reg   <= 8'd160;
            abc_reg    <= 2'd2;
            page_reg   <= 4'd6;
            msize_reg  <= 17'd32768;
            plimit_reg <= 10'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DSEL:  dsel_reg   <= cfg_data[7:0];
                CFG_ABC:   abc_reg    <= cfg_data[1:0];
                CFG_PAGE:  page_reg   <= cfg_data[3:0];
                CFG_MSIZE: msize_reg  <= cfg_data;
                CFG_POLL:  plimit_reg <= cfg_data[9:0];
                default:
                begin
                    dsel_reg <= dsel_reg;
                end
            endcase
        end
    end

endmodule

// ===== rtl/i2cees_fifo.sv =====
// ----------------------------------------------------------------------------
// i2cees_fifo: result group queue
// Short flop-based queue of result groups between request decode and output.
// ----------------------------------------------------------------------------
module i2cees_fifo #(
    parameter int DEPTH = i2cees_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  i2cees_pkg::res_group_t push_group,
    output logic                   full,
    input  logic                   pop,
    output logic                   not_empty,
    output i2cees_pkg::res_group_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i2cees_pkg::res_group_t mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_group;
        end
    end

endmodule

// ===== rtl/i2cees_back.sv =====
// ----------------------------------------------------------------------------
// i2cees_back: result serializer
// Holds one result group and sends its entries one per cycle while out_ready is high, marking the last.
// ----------------------------------------------------------------------------
module i2cees_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_not_empty,
    input  i2cees_pkg::res_group_t q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3:0]             action,
    output logic [7:0]             byte_out,
    output logic                   success,
    output logic                   last
);

    i2cees_pkg::res_group_t grp_reg;
    logic                   have_reg, have_next;
    logic [1:0]             idx_reg, idx_next;
    logic                   sent;
    i2cees_pkg::res_entry_t cur;

    assign cur       = grp_reg.ent[idx_reg];
    assign out_valid = have_reg;
    assign action    = cur.action;
    assign byte_out  = cur.byte_val;
    assign success   = cur.success;
    assign last      = ({1'b0, idx_reg} == grp_reg.count - 3'd1);
    assign sent      = have_reg && out_ready;
    // reload as soon as the held group is empty or its final entry goes out
    assign q_pop     = q_not_empty && (!have_reg || (sent && last));

    always_comb
    begin
        have_next = have_reg;
        idx_next  = idx_reg;
        if (q_pop)
        begin
            have_next = 1'b1;
            idx_next  = '0;
        end
        else if (sent)
        begin
            if (last)
            begin
                have_next = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            have_reg <= have_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            grp_reg <= q_head;
        end
    end

endmodule

// ===== rtl/i2c_eeprom_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_eeprom_transfer_sequencer: serial EEPROM page write / random read master
// Top level: request decoder, result group queue and result serializer.
// ----------------------------------------------------------------------------
// A request (command, write byte, ack result or received byte) is taken
// whenever the result queue has a free slot; the decoder updates the
// transfer state at once, so requests may follow back to back. Each
// request yields zero to four bus actions, which leave the output channel
// one per cycle while out_ready is high, and the QUEUE_DEPTH-entry result
// queue absorbs bursts. Requests that cause no action never occupy the
// queue. Configuration writes are always taken and apply from the next
// cycle.
module i2c_eeprom_transfer_sequencer #(
    parameter int ADDRESS_WIDTH = i2cees_pkg::ADDRESS_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH   = i2cees_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [15:0] start_address,
    input  logic [15:0] byte_count,
    input  logic [7:0]  data_byte,
    input  logic        no_ack,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  action,
    output logic [7:0]  byte_out,
    output logic        success,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    i2cees_pkg::res_group_t push_group;
    i2cees_pkg::res_group_t q_head;
    logic                   push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_not_empty;

    i2cees_front #(
        .ADDRESS_WIDTH(ADDRESS_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .start_address(start_address),
        .byte_count   (byte_count),
        .data_byte    (data_byte),
        .no_ack       (no_ack),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .queue_full   (q_full),
        .push         (push),
        .push_group   (push_group)
    );

    i2cees_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_group(push_group),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    i2cees_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_not_empty(q_not_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .action     (action),
        .byte_out   (byte_out),
        .success    (success),
        .last       (last)
    );

endmodule

// ===== rtl/i2cees_checker.sv =====
// ----------------------------------------------------------------------------
// i2cees_checker: port-level checks of the transfer sequencer
// Watches the result channel of the top level; bound in below.
// ----------------------------------------------------------------------------
module i2cees_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] action,
    input logic [7:0] byte_out,
    input logic       success,
    input logic       last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(byte_out)
            && $stable(success) && $stable(last))
        else $error("result changed while stalled");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == i2cees_pkg::A_DONE |-> last)
        else $error("done status not last of its request");

    a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != i2cees_pkg::A_DONE |-> !success)
        else $error("success flag outside done status");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != i2cees_pkg::A_SEND && action != i2cees_pkg::A_RDATA
            |-> byte_out == 8'd0)
        else $error("byte present on action without data");

endmodule

bind i2c_eeprom_transfer_sequencer i2cees_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .action   (action),
    .byte_out (byte_out),
    .success  (success),
    .last     (last)
);

// ===== bench/transfer_checker.sv =====
// ----------------------------------------------------------------------------
// transfer_checker: result predictor and comparator for the EEPROM sequencer
// Watches the request, result and register channels, keeps its own copy of
// the transfer state, predicts the bus actions of every accepted request and
// compares them in order with the results that leave the block.
// ----------------------------------------------------------------------------
package i2cees_tb_pkg;

    // request op codes
    localparam logic [2:0] OP_BEGIN_WRITE = 3'd0;
    localparam logic [2:0] OP_BEGIN_READ  = 3'd1;
    localparam logic [2:0] OP_WRITE_BYTE  = 3'd2;
    localparam logic [2:0] OP_ACK_RESULT  = 3'd3;
    localparam logic [2:0] OP_RX_BYTE     = 3'd4;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // register indexes
    localparam logic [2:0] REG_DEVICE_SELECT = 3'd0;
    localparam logic [2:0] REG_ADDRESS_BYTES = 3'd1;
    localparam logic [2:0] REG_PAGE_LOG2     = 3'd2;
    localparam logic [2:0] REG_MEMORY_SIZE   = 3'd3;
    localparam logic [2:0] REG_POLL_LIMIT    = 3'd4;

    typedef enum logic [3:0] {
        XFER_IDLE,
        XFER_DEVICE,
        XFER_ADDR_HI,
        XFER_ADDR_LO,
        XFER_DATA,
        XFER_WRITE_ACK,
        XFER_READ_DEVICE,
        XFER_RECEIVE
    } xfer_phase_t;

    typedef struct packed {
        logic [3:0] action;
        logic [7:0] byte_val;
        logic       success;
        logic       last;
    } bus_result_t;

endpackage

module transfer_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [2:0]                 op,
    input  logic [15:0]                start_address,
    input  logic [15:0]                byte_count,
    input  logic [7:0]                 data_byte,
    input  logic                       no_ack,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [3:0]                 action,
    input  logic [7:0]                 byte_out,
    input  logic                       success,
    input  logic                       last,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [16:0]                cfg_data,
    output int                         mismatch_count,
    output int                         results_owed,
    output i2cees_tb_pkg::xfer_phase_t phase_now
);
    import i2cees_pkg::*;
    import i2cees_tb_pkg::*;

    localparam logic [1:0] TWO_ADDRESS_BYTES = 2'd2;
    localparam int         REPORT_LIMIT      = 10;

    // register copies
    logic [7:0]  dev_sel;
    logic [1:0]  addr_bytes;
    logic [3:0]  page_log2;
    logic [16:0] mem_bytes;
    logic [9:0]  poll_max;

    // transfer state
    xfer_phase_t xfer_phase;
    logic        reading;
    logic [15:0] addr_ptr;
    logic [16:0] bytes_left;
    logic        first_write;
    logic [9:0]  polls;

    bus_result_t step_res [0:3];
    int          step_n;
    bus_result_t expected_q [$];

    assign phase_now = xfer_phase;

    function automatic logic [7:0] device_byte(input logic rw);
        logic [6:0] upper;
        upper = dev_sel[7:1];
        // one-byte addressing carries address bits 14..8 in the device byte
        if (addr_bytes != TWO_ADDRESS_BYTES)
        begin
            upper = upper | addr_ptr[14:8];
        end
        return {upper, rw};
    endfunction

    task automatic put_result(input logic [3:0] act, input logic [7:0] val, input logic ok);
        bus_result_t r;
        r.action   = act;
        r.byte_val = val;
        r.success  = ok;
        r.last     = 1'b0;
        step_res[step_n] = r;
        step_n = step_n + 1;
    endtask

    task automatic wrap_up(input logic ok);
        put_result(A_STOP, 8'h00, 1'b0);
        put_result(A_DONE, 8'h00, ok);
        xfer_phase = XFER_IDLE;
    endtask

    task automatic address_device();
        put_result(A_START, 8'h00, 1'b0);
        put_result(A_SEND, device_byte(1'b0), 1'b0);
        xfer_phase = XFER_DEVICE;
    endtask

    task automatic continue_write();
        logic [16:0] page_mask;
        page_mask = (17'd1 << page_log2) - 17'd1;
        if (bytes_left == 17'd0)
        begin
            wrap_up(1'b1);
        end
        else if (first_write || (addr_ptr & page_mask[15:0]) == 16'd0)
        begin
            // re-address at the first byte and at every page boundary
            put_result(A_STOP, 8'h00, 1'b0);
            polls = 10'd0;
            address_device();
        end
        else
        begin
            put_result(A_WANT, 8'h00, 1'b0);
            xfer_phase = XFER_DATA;
        end
    endtask

    task automatic handle_request(input logic [2:0]  req_op,
                                  input logic [15:0] req_addr,
                                  input logic [15:0] req_count,
                                  input logic [7:0]  req_data,
                                  input logic        req_nak);
        bus_result_t r;
        int          i;
        step_n = 0;
        case (req_op)
            OP_BEGIN_WRITE, OP_BEGIN_READ:
            begin
                reading     = (req_op == OP_BEGIN_READ);
                addr_ptr    = req_addr;
                bytes_left  = {1'b0, req_count};
                first_write = 1'b1;
                polls       = 10'd0;
                if (({2'b00, req_addr} + {2'b00, req_count}) > {1'b0, mem_bytes})
                begin
                    wrap_up(1'b0);
                end
                else if (!reading)
                begin
                    continue_write();
                end
                else
                begin
                    put_result(A_STOP, 8'h00, 1'b0);
                    address_device();
                end
            end
            OP_WRITE_BYTE:
            begin
                if (xfer_phase == XFER_DATA)
                begin
                    put_result(A_SEND, req_data, 1'b0);
                    xfer_phase = XFER_WRITE_ACK;
                end
            end
            OP_ACK_RESULT:
            begin
                case (xfer_phase)
                    XFER_DEVICE:
                    begin
                        if (req_nak)
                        begin
                            // acknowledge polling: retry until the limit
                            polls = polls + 10'd1;
                            if (polls >= poll_max || polls == 10'd0)
                            begin
                                wrap_up(1'b0);
                            end
                            else
                            begin
                                address_device();
                            end
                        end
                        else if (addr_bytes == TWO_ADDRESS_BYTES)
                        begin
                            put_result(A_SEND, addr_ptr[15:8], 1'b0);
                            xfer_phase = XFER_ADDR_HI;
                        end
                        else
                        begin
                            put_result(A_SEND, addr_ptr[7:0], 1'b0);
                            xfer_phase = XFER_ADDR_LO;
                        end
                    end
                    XFER_ADDR_HI:
                    begin
                        if (req_nak)
                        begin
                            wrap_up(1'b0);
                        end
                        else
                        begin
                            put_result(A_SEND, addr_ptr[7:0], 1'b0);
                            xfer_phase = XFER_ADDR_LO;
                        end
                    end
                    XFER_ADDR_LO:
                    begin
                        if (req_nak)
                        begin
                            wrap_up(1'b0);
                        end
                        else if (reading)
                        begin
                            // repeated start with the read bit
                            put_result(A_START, 8'h00, 1'b0);
                            put_result(A_SEND, device_byte(1'b1), 1'b0);
                            xfer_phase = XFER_READ_DEVICE;
                        end
                        else
                        begin
                            put_result(A_WANT, 8'h00, 1'b0);
                            xfer_phase = XFER_DATA;
                        end
                    end
                    XFER_WRITE_ACK:
                    begin
                        if (req_nak)
                        begin
                            wrap_up(1'b0);
                        end
                        else
                        begin
                            addr_ptr    = addr_ptr + 16'd1;
                            bytes_left  = bytes_left - 17'd1;
                            first_write = 1'b0;
                            continue_write();
                        end
                    end
                    XFER_READ_DEVICE:
                    begin
                        if (req_nak)
                        begin
                            wrap_up(1'b0);
                        end
                        else if (bytes_left == 17'd0)
                        begin
                            wrap_up(1'b1);
                        end
                        else
                        begin
                            put_result(A_READ, 8'h00, 1'b0);
                            xfer_phase = XFER_RECEIVE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_RX_BYTE:
            begin
                if (xfer_phase == XFER_RECEIVE)
                begin
                    put_result(A_RDATA, req_data, 1'b0);
                    addr_ptr   = addr_ptr + 16'd1;
                    bytes_left = bytes_left - 17'd1;
                    if (bytes_left != 17'd0)
                    begin
                        put_result(A_ACK, 8'h00, 1'b0);
                        put_result(A_READ, 8'h00, 1'b0);
                    end
                    else
                    begin
                        put_result(A_NACK, 8'h00, 1'b0);
                        wrap_up(1'b1);
                    end
                end
            end
            default:
            begin
            end
        endcase
        for (i = 0; i < step_n; i = i + 1)
        begin
            r = step_res[i];
            r.last = (i == step_n - 1);
            expected_q.push_back(r);
        end
    endtask

    task automatic check_result();
        bus_result_t got;
        bus_result_t want;
        got.action   = action;
        got.byte_val = byte_out;
        got.success  = success;
        got.last     = last;
        if (expected_q.size() == 0)
        begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= REPORT_LIMIT)
            begin
                $display("transfer_checker: result with nothing pending: %0d %02h %0b %0b",
                         got.action, got.byte_val, got.success, got.last);
            end
        end
        else
        begin
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("transfer_checker: expected action %0d byte %02h ok %0b last %0b",
                             want.action, want.byte_val, want.success, want.last);
                    $display("transfer_checker:      got action %0d byte %02h ok %0b last %0b",
                             got.action, got.byte_val, got.success, got.last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_sel        = 8'hA0;
            addr_bytes     = 2'd2;
            page_log2      = 4'd6;
            mem_bytes      = 17'd32768;
            poll_max       = 10'd1000;
            xfer_phase     = XFER_IDLE;
            reading        = 1'b0;
            addr_ptr       = 16'd0;
            bytes_left     = 17'd0;
            first_write    = 1'b1;
            polls          = 10'd0;
            step_n         = 0;
            expected_q.delete();
            mismatch_count = 0;
            results_owed   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                handle_request(op, start_address, byte_count, data_byte, no_ack);
            end
            // register writes take effect from the next cycle
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DEVICE_SELECT: dev_sel    = cfg_data[7:0];
                    REG_ADDRESS_BYTES: addr_bytes = cfg_data[1:0];
                    REG_PAGE_LOG2:     page_log2  = cfg_data[3:0];
                    REG_MEMORY_SIZE:   mem_bytes  = cfg_data;
                    REG_POLL_LIMIT:    poll_max   = cfg_data[9:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && out_ready)
            begin
                check_result();
            end
            results_owed = expected_q.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench top of the I2C EEPROM transfer sequencer
// Drives requests with random idle gaps, programs the registers, stalls the
// result channel, walks the block through directed and protocol-aware random
// transfers under several register settings and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import i2cees_pkg::*;
    import i2cees_tb_pkg::*;

    localparam int MAX_IDLE        = 6;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int SETTLE_CYCLES   = 8;
    // longest legal quiet stretch is the output hold-off; allow many times it
    localparam int WATCHDOG_LIMIT  = 4000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  op;
    logic [15:0] start_address;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;
    logic        no_ack;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  action;
    logic [7:0]  byte_out;
    logic        success;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    int          mismatch_count;
    int          results_owed;
    xfer_phase_t phase_now;

    // stimulus-side view of the register settings
    int          cur_page_log2;
    int          cur_mem_size;
    bit          quiet_mode;
    bit          hold_off_req;
    int          requests_sent;
    int          results_taken;
    int          settings_loaded;
    int          stalled_cycles;

    i2c_eeprom_transfer_sequencer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .start_address (start_address),
        .byte_count    (byte_count),
        .data_byte     (data_byte),
        .no_ack        (no_ack),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .action        (action),
        .byte_out      (byte_out),
        .success       (success),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    transfer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .start_address  (start_address),
        .byte_count     (byte_count),
        .data_byte      (data_byte),
        .no_ack         (no_ack),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .action         (action),
        .byte_out       (byte_out),
        .success        (success),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed),
        .phase_now      (phase_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // called and returns at a falling edge
    task automatic issue(input logic [2:0]  req_op,
                         input logic [15:0] req_addr,
                         input logic [15:0] req_count,
                         input logic [7:0]  req_data,
                         input logic        req_nak);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        op            = req_op;
        start_address = req_addr;
        byte_count    = req_count;
        data_byte     = req_data;
        no_ack        = req_nak;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent = requests_sent + 1;
        @(negedge clk);
    endtask

    task automatic report_ack(input logic nak);
        issue(OP_ACK_RESULT, 16'($urandom), 16'($urandom), 8'($urandom), nak);
    endtask

    // hold requests until every predicted result has left the block
    task automatic settle();
        in_valid = 1'b0;
        while (results_owed != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_reg(input logic [2:0] index, input logic [16:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [7:0] dsel, input int abc, input int pg,
                                 input int mem, input int poll_lim);
        settle();
        program_reg(REG_DEVICE_SELECT, {9'd0, dsel});
        program_reg(REG_ADDRESS_BYTES, abc[16:0]);
        program_reg(REG_PAGE_LOG2, pg[16:0]);
        program_reg(REG_MEMORY_SIZE, mem[16:0]);
        program_reg(REG_POLL_LIMIT, poll_lim[16:0]);
        cfg_valid       = 1'b0;
        cur_page_log2   = pg;
        cur_mem_size    = mem;
        settings_loaded = settings_loaded + 1;
    endtask

    // mostly the request the current transfer phase is waiting for
    task automatic random_request(output bit well_formed);
        logic [2:0]  o;
        logic [15:0] a;
        logic [15:0] c;
        logic [7:0]  d;
        logic        k;
        int          span;
        int          upper;
        int          base;
        int          pg_bytes;
        a = 16'($urandom);
        c = 16'($urandom);
        d = 8'($urandom);
        k = 1'b0;
        well_formed = ($urandom_range(0, 99) >= 12);
        if (!well_formed)
        begin
            o = 3'($urandom_range(0, OP_SPARE_LAST));
            k = 1'($urandom);
        end
        else
        begin
            case (phase_now)
                XFER_IDLE:
                begin
                    o = $urandom_range(0, 1) ? OP_BEGIN_READ : OP_BEGIN_WRITE;
                    case ($urandom_range(0, 9))
                        0:
                        begin
                        end
                        1:
                        begin
                            c = 16'd0;
                            upper = (cur_mem_size > 65535) ? 65535 : cur_mem_size;
                            base = $urandom_range(0, upper);
                            a = base[15:0];
                        end
                        2:
                        begin
                            // one past the end of memory
                            span = $urandom_range(1, 4);
                            base = cur_mem_size - span + 1;
                            if (base < 0)
                            begin
                                base = 0;
                                span = cur_mem_size + 1;
                            end
                            if (base > 65535)
                            begin
                                base = 65535;
                                span = cur_mem_size + 1 - 65535;
                            end
                            a = base[15:0];
                            c = span[15:0];
                        end
                        default:
                        begin
                            // short transfers that often straddle a page boundary
                            span = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12)
                                                               : $urandom_range(1, 4);
                            if (span > cur_mem_size)
                            begin
                                span = cur_mem_size;
                            end
                            upper = cur_mem_size - span;
                            if (upper > 65535)
                            begin
                                upper = 65535;
                            end
                            pg_bytes = 1 << cur_page_log2;
                            base = $urandom_range(0, upper);
                            base = base - (base % pg_bytes) + pg_bytes - $urandom_range(1, 2);
                            if (base < 0 || base > upper)
                            begin
                                base = $urandom_range(0, upper);
                            end
                            a = base[15:0];
                            c = span[15:0];
                        end
                    endcase
                end
                XFER_DEVICE:
                begin
                    o = OP_ACK_RESULT;
                    k = ($urandom_range(0, 3) == 0);
                end
                XFER_DATA:
                begin
                    o = OP_WRITE_BYTE;
                end
                XFER_RECEIVE:
                begin
                    o = OP_RX_BYTE;
                end
                default:
                begin
                    o = OP_ACK_RESULT;
                    k = ($urandom_range(0, 19) == 0);
                end
            endcase
        end
        issue(o, a, c, d, k);
    endtask

    task automatic run_random(input int n);
        int done_n;
        bit counted;
        done_n = 0;
        while (done_n < n)
        begin
            random_request(counted);
            if (counted)
            begin
                done_n = done_n + 1;
            end
        end
    endtask

    // result side: random stall per result, long hold-off on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        while (rst_n !== 1'b1) @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            stall = quiet_mode ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                stalled_cycles = 0;
            end
            else
            begin
                stalled_cycles = stalled_cycles + 1;
            end
            if (out_valid && out_ready)
            begin
                results_taken = results_taken + 1;
            end
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top: no handshake for %0d cycles", stalled_cycles);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        op              = OP_BEGIN_WRITE;
        start_address   = 16'd0;
        byte_count      = 16'd0;
        data_byte       = 8'd0;
        no_ack          = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_DEVICE_SELECT;
        cfg_data        = 17'd0;
        quiet_mode      = 1'b0;
        hold_off_req    = 1'b0;
        requests_sent   = 0;
        results_taken   = 0;
        settings_loaded = 0;
        stalled_cycles  = 0;
        cur_page_log2   = 6;
        cur_mem_size    = 32768;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, reset settings
        // spare op codes and a stray ack are ignored while idle
        issue(OP_SPARE_FIRST, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        issue(OP_SPARE_LAST, 16'h0000, 16'h0000, 8'h00, 1'b0);
        report_ack(1'b0);
        // range overflow at the field extremes
        issue(OP_BEGIN_WRITE, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0);
        // zero-length write ends at once
        issue(OP_BEGIN_WRITE, 16'h0000, 16'h0000, 8'h00, 1'b0);
        // zero-length read still runs the addressing sequence
        issue(OP_BEGIN_READ, 16'h1234, 16'h0000, 8'h00, 1'b0);
        repeat (4) report_ack(1'b0);
        // one byte at the top of memory, one polling retry first
        issue(OP_BEGIN_WRITE, 16'h7FFF, 16'h0001, 8'h00, 1'b0);
        report_ack(1'b1);
        repeat (3) report_ack(1'b0);
        issue(OP_WRITE_BYTE, 16'h0000, 16'h0000, 8'hFF, 1'b0);
        report_ack(1'b0);
        // two-byte read: ack between bytes, nack after the last
        issue(OP_BEGIN_READ, 16'h0000, 16'h0002, 8'h00, 1'b0);
        repeat (4) report_ack(1'b0);
        issue(OP_RX_BYTE, 16'h0000, 16'h0000, 8'h00, 1'b0);
        issue(OP_RX_BYTE, 16'h0000, 16'h0000, 8'hFF, 1'b0);
        // abandon a read with a new write, then drop the high address ack
        issue(OP_BEGIN_READ, 16'h7FF0, 16'h0010, 8'h00, 1'b0);
        report_ack(1'b0);
        issue(OP_BEGIN_WRITE, 16'h0002, 16'h0001, 8'h00, 1'b0);
        report_ack(1'b0);
        report_ack(1'b1);

        // random part under several settings
        load_settings(8'hA0, 2, 6, 32768, 1000);
        run_random(5);
        // stall the result side long enough to back up the request side
        hold_off_req = 1'b1;
        run_random(15);

        load_settings(8'hFE, 1, 0, 1, 1);
        run_random(8);

        load_settings(8'h00, 1, 8, 65536, 3);
        quiet_mode = 1'b1;
        run_random(10);
        quiet_mode = 1'b0;
        run_random(10);

        load_settings({7'($urandom), 1'b0}, 2, 3, 4096, 2);
        run_random(8);
        settle();
        run_random(9);

        settle();
        $display("tb_top: %0d requests, %0d results checked over %0d register settings",
                 requests_sent, results_taken, settings_loaded);
        $display("tb_top: included page restarts, polling, reads, aborts and back-pressure");
        if (mismatch_count == 0 && results_owed == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
